@@ hdl/lsp_pkg.sv @@
package lsp_pkg;

   // fixed field widths
   localparam int DATA_WIDTH = 32;
   localparam int CAP_WIDTH = 7;
   localparam int POS_WIDTH = 7;
   localparam int MODE_WIDTH = 2;
   localparam int STATUS_WIDTH = 2;

   // storage defaults
   localparam int DEFAULT_DEPTH = 64;
   localparam logic [CAP_WIDTH-1:0] CAPACITY_RESET = 7'd64;

   // request operations
   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_PUSH = 2'd0,
      MODE_POP  = 2'd1,
      MODE_PEEK = 2'd2,
      MODE_NOP  = 2'd3
   } mode_type;

   // result codes
   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_BAD_POS   = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic exec;
      logic load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

@@ hdl/lsp_req_if.sv @@
interface lsp_req_if import lsp_pkg::*; ();

   logic                         valid;
   logic                         ready;
   logic [MODE_WIDTH-1:0]        mode;
   logic signed [DATA_WIDTH-1:0] push_value;
   logic [POS_WIDTH-1:0]         position;

   modport source (output valid, output mode, output push_value, output position,
                   input ready);
   modport sink (input valid, input mode, input push_value, input position,
                 output ready);

endinterface

@@ hdl/lsp_rsp_if.sv @@
interface lsp_rsp_if import lsp_pkg::*; ();

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] read_value;
   logic [STATUS_WIDTH-1:0]      status;
   logic                         is_empty;
   logic                         is_full;

   modport source (output valid, output read_value, output status, output is_empty,
                   output is_full, input ready);
   modport sink (input valid, input read_value, input status, input is_empty,
                 input is_full, output ready);

endinterface

@@ hdl/lifo_stack_with_peek_unit.sv @@
// the request is executed into the pending registers, then loaded into the output register
// the controller alternates transfer and output load; no new request is taken before the load
// the load waits while the output register holds a result not yet taken
// a new request is taken while the previous result waits in the output register
// reset (synchronous, active high) empties the stack and sets capacity to 64;
// stored words are not cleared
module lifo_stack_with_peek_unit import lsp_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   lsp_req_if.sink              req_if,
   lsp_rsp_if.source            rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CAP_WIDTH-1:0] csr_wr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_stat;

   // sequencing
   lsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   // stack storage and result path
   lsp_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .dp_stat        (dp_stat),
      .req_mode       (req_if.mode),
      .req_push_value (req_if.push_value),
      .req_position   (req_if.position),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_read_value (rsp_if.read_value),
      .rsp_status     (rsp_if.status),
      .rsp_is_empty   (rsp_if.is_empty),
      .rsp_is_full    (rsp_if.is_full)
   );

endmodule

@@ hdl/lsp_ctrl.sv @@
module lsp_ctrl import lsp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_stat,
   output ctrl_cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_LOAD
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && ready_ff) begin
                  state_ff <= S_LOAD;
                  ready_ff <= 1'b0;
               end
            end
            S_LOAD: begin
               if (dp_stat.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
         endcase
      end
   end

   // commands to the datapath
   assign req_ready = ready_ff;
   assign cmd.exec  = req_valid && ready_ff;
   assign cmd.load  = (state_ff == S_LOAD) && dp_stat.out_free;

endmodule

@@ hdl/lsp_datapath.sv @@
module lsp_datapath import lsp_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctrl_cmd_type                 cmd,
   output dp_status_type                dp_stat,
   input  logic [MODE_WIDTH-1:0]        req_mode,
   input  logic signed [DATA_WIDTH-1:0] req_push_value,
   input  logic [POS_WIDTH-1:0]         req_position,
   input  logic                         csr_wr_en,
   input  logic [CAP_WIDTH-1:0]         csr_wr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_read_value,
   output logic [STATUS_WIDTH-1:0]      rsp_status,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;
   localparam logic [CMPW-1:0] DEPTH_EXT = CMPW'(DEPTH);

   // stack storage
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // control state
   logic [CW-1:0]        count_ff;
   logic [CAP_WIDTH-1:0] capacity_ff;
   logic                 rsp_valid_ff;

   // values held between execute and output load
   status_type pend_status_ff;
   logic       pend_mem_ff;
   logic       pend_empty_ff;
   logic       pend_full_ff;

   // output register
   logic signed [DATA_WIDTH-1:0] rsp_read_value_ff;
   status_type                   rsp_status_ff;
   logic                         rsp_is_empty_ff;
   logic                         rsp_is_full_ff;

   // execute-stage decode
   mode_type      mode_in;
   logic [CMPW-1:0] cnt_ext;
   logic [CMPW-1:0] pos_ext;
   logic [CMPW-1:0] cap_eff;
   logic [CMPW-1:0] slot;
   logic [CW-1:0]   count_in;
   status_type      status_in;
   logic            use_mem_in;
   logic            wr_en_in;
   logic [AW-1:0]   rd_addr;
   logic            empty_in;
   logic            full_in;

   always_comb begin
      mode_in    = mode_type'(req_mode);
      cnt_ext    = CMPW'(count_ff);
      pos_ext    = CMPW'(req_position);
      cap_eff    = (CMPW'(capacity_ff) > DEPTH_EXT) ? DEPTH_EXT : CMPW'(capacity_ff);
      slot       = cnt_ext - CMPW'(1);
      count_in   = count_ff;
      status_in  = ST_OK;
      use_mem_in = 1'b0;
      wr_en_in   = 1'b0;
      unique case (mode_in)
         MODE_PUSH: begin
            if (cnt_ext >= cap_eff) begin
               status_in = ST_OVERFLOW;
            end else begin
               wr_en_in = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         MODE_POP: begin
            if (count_ff == '0) begin
               status_in = ST_UNDERFLOW;
            end else begin
               use_mem_in = 1'b1;
               count_in   = count_ff - CW'(1);
            end
         end
         MODE_PEEK: begin
            slot = cnt_ext - pos_ext;
            if (pos_ext == '0 || pos_ext > cnt_ext) begin
               status_in = ST_BAD_POS;
            end else begin
               use_mem_in = 1'b1;
            end
         end
         MODE_NOP: begin
         end
      endcase
      rd_addr  = slot[AW-1:0];
      empty_in = (count_in == '0);
      full_in  = (CMPW'(count_in) >= cap_eff);
   end

   // memory: at most one write and one registered read per request
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en_in) begin
         mem[count_ff[AW-1:0]] <= req_push_value;
      end
      if (cmd.exec) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (cmd.exec) begin
            count_ff <= count_in;
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         pend_status_ff <= status_in;
         pend_mem_ff    <= use_mem_in;
         pend_empty_ff  <= empty_in;
         pend_full_ff   <= full_in;
      end
      if (cmd.load) begin
         rsp_read_value_ff <= pend_mem_ff ? rd_data_ff : '1;
         rsp_status_ff     <= pend_status_ff;
         rsp_is_empty_ff   <= pend_empty_ff;
         rsp_is_full_ff    <= pend_full_ff;
      end
   end

   // output register is free when empty or being taken
   assign dp_stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_is_empty   = rsp_is_empty_ff;
   assign rsp_is_full    = rsp_is_full_ff;

endmodule
